// ===== src/tagf_pkg.sv =====
// ----------------------------------------------------------------------------
// tagf_pkg
// shared beat types and pipeline constants for the triangle area gradient unit
// ----------------------------------------------------------------------------
package tagf_pkg;

	typedef struct packed {
		logic signed [31:0] a_x;
		logic signed [31:0] a_y;
		logic signed [31:0] a_z;
		logic signed [31:0] b_x;
		logic signed [31:0] b_y;
		logic signed [31:0] b_z;
		logic signed [31:0] c_x;
		logic signed [31:0] c_y;
		logic signed [31:0] c_z;
	} in_beat_t;

	typedef struct packed {
		logic signed [31:0] fa_x;
		logic signed [31:0] fa_y;
		logic signed [31:0] fa_z;
		logic signed [31:0] fb_x;
		logic signed [31:0] fb_y;
		logic signed [31:0] fb_z;
		logic signed [31:0] fc_x;
		logic signed [31:0] fc_y;
		logic signed [31:0] fc_z;
		logic               degenerate;
	} out_beat_t;

	typedef logic signed [32:0] edge_t;
	typedef logic signed [30:0] nrm_t;

	localparam int FRONT_STAGES = 7;
	localparam int SQRT_STAGES  = 31;
	localparam int DIV_STAGES   = 31;
	localparam int BACK_STAGES  = 5;
	localparam int LATENCY      = FRONT_STAGES + SQRT_STAGES + DIV_STAGES + 1 + BACK_STAGES;

	localparam logic [29:0]        NRM_MAX  = 30'h2000_0000;
	localparam logic signed [31:0] FS_RESET = 32'sh0001_0000;

endpackage

// ===== src/tagf_front.sv =====
// ----------------------------------------------------------------------------
// tagf_front
// edges, exact cross product, normalization to 30 bits and sum of squares
// ----------------------------------------------------------------------------
module tagf_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                vld,
	input  tagf_pkg::in_beat_t  beat,
	output logic                out_vld,
	output logic [29:0]         v_mag [3],
	output logic [2:0]          v_neg,
	output logic                degenerate,
	output tagf_pkg::edge_t     bc [3],
	output tagf_pkg::edge_t     ca [3],
	output logic [61:0]         sum
);

	logic                  vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	tagf_pkg::edge_t       ab_s1 [3], bc_s1 [3], ca_s1 [3];
	tagf_pkg::edge_t       bc_s2 [3], ca_s2 [3], bc_s3 [3], ca_s3 [3];
	tagf_pkg::edge_t       bc_s4 [3], ca_s4 [3], bc_s5 [3], ca_s5 [3];
	tagf_pkg::edge_t       bc_s6 [3], ca_s6 [3], bc_s7 [3], ca_s7 [3];
	logic signed [65:0]    p_s2 [6];
	logic [66:0]           m_s3 [3], m_s4 [3];
	logic [2:0]            n_s3, n_s4, n_s5, n_s6, n_s7;
	logic [6:0]            len_s4;
	logic [29:0]           v_s5 [3], v_s6 [3], v_s7 [3];
	logic [59:0]           sq_s6 [3];
	logic [61:0]           sum_s7;
	logic                  dg_s4, dg_s5, dg_s6, dg_s7;

	logic signed [31:0]    pin [9];
	logic signed [66:0]    cr [3];
	logic [66:0]           orm;
	logic [6:0]            len;

	assign pin[0] = beat.a_x;
	assign pin[1] = beat.a_y;
	assign pin[2] = beat.a_z;
	assign pin[3] = beat.b_x;
	assign pin[4] = beat.b_y;
	assign pin[5] = beat.b_z;
	assign pin[6] = beat.c_x;
	assign pin[7] = beat.c_y;
	assign pin[8] = beat.c_z;

	assign cr[0] = 67'(p_s2[0]) - 67'(p_s2[1]);
	assign cr[1] = 67'(p_s2[2]) - 67'(p_s2[3]);
	assign cr[2] = 67'(p_s2[4]) - 67'(p_s2[5]);

	assign orm = m_s3[0] | m_s3[1] | m_s3[2];

	always_comb begin
		len = '0;
		for (int i = 0; i < 67; i++) begin
			if (orm[i]) begin
				len = 7'(i + 1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			ab_s1[i] <= 33'(pin[3 + i]) - 33'(pin[i]);
			bc_s1[i] <= 33'(pin[6 + i]) - 33'(pin[3 + i]);
			ca_s1[i] <= 33'(pin[i]) - 33'(pin[6 + i]);
		end
		p_s2[0] <= ab_s1[1] * bc_s1[2];
		p_s2[1] <= ab_s1[2] * bc_s1[1];
		p_s2[2] <= ab_s1[2] * bc_s1[0];
		p_s2[3] <= ab_s1[0] * bc_s1[2];
		p_s2[4] <= ab_s1[0] * bc_s1[1];
		p_s2[5] <= ab_s1[1] * bc_s1[0];
		for (int i = 0; i < 3; i++) begin
			m_s3[i] <= cr[i][66] ? 67'(-cr[i]) : 67'(cr[i]);
			n_s3[i] <= cr[i][66];
		end
		m_s4   <= m_s3;
		n_s4   <= n_s3;
		len_s4 <= len;
		dg_s4  <= (len == 7'd0);
		for (int i = 0; i < 3; i++) begin
			if (len_s4 > 7'd30) begin
				v_s5[i] <= 30'(m_s4[i] >> (len_s4 - 7'd30));
			end else begin
				v_s5[i] <= 30'(m_s4[i] << (7'd30 - len_s4));
			end
		end
		n_s5  <= n_s4;
		dg_s5 <= dg_s4;
		for (int i = 0; i < 3; i++) begin
			sq_s6[i] <= v_s5[i] * v_s5[i];
		end
		v_s6   <= v_s5;
		n_s6   <= n_s5;
		dg_s6  <= dg_s5;
		sum_s7 <= 62'(sq_s6[0]) + 62'(sq_s6[1]) + 62'(sq_s6[2]);
		v_s7   <= v_s6;
		n_s7   <= n_s6;
		dg_s7  <= dg_s6;
		bc_s2 <= bc_s1;
		ca_s2 <= ca_s1;
		bc_s3 <= bc_s2;
		ca_s3 <= ca_s2;
		bc_s4 <= bc_s3;
		ca_s4 <= ca_s3;
		bc_s5 <= bc_s4;
		ca_s5 <= ca_s4;
		bc_s6 <= bc_s5;
		ca_s6 <= ca_s5;
		bc_s7 <= bc_s6;
		ca_s7 <= ca_s6;
	end

	assign out_vld    = vld_s7;
	assign v_mag      = v_s7;
	assign v_neg      = n_s7;
	assign degenerate = dg_s7;
	assign bc         = bc_s7;
	assign ca         = ca_s7;
	assign sum        = sum_s7;

endmodule

// ===== src/tagf_isqrt.sv =====
// ----------------------------------------------------------------------------
// tagf_isqrt
// pipelined floor square root, one result bit per stage
// ----------------------------------------------------------------------------
module tagf_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        vld,
	input  logic [61:0] op,
	output logic        out_vld,
	output logic [30:0] root
);

	localparam int N = tagf_pkg::SQRT_STAGES;

	logic        vld_s [N];
	logic [61:0] op_s  [N];
	logic [34:0] rem_s [N];
	logic [30:0] res_s [N];

	for (genvar i = 0; i < N; i++) begin : g_st
		localparam int K = N - 1 - i;
		logic        vld_i;
		logic [61:0] op_i;
		logic [34:0] rem_i, rem2, trial;
		logic [30:0] res_i;
		logic        ge;

		if (i == 0) begin : g_first
			assign vld_i = vld;
			assign op_i  = op;
			assign rem_i = '0;
			assign res_i = '0;
		end else begin : g_next
			assign vld_i = vld_s[i - 1];
			assign op_i  = op_s[i - 1];
			assign rem_i = rem_s[i - 1];
			assign res_i = res_s[i - 1];
		end

		assign rem2  = {rem_i[32:0], op_i[2 * K + 1 -: 2]};
		assign trial = {2'b00, res_i, 2'b01};
		assign ge    = (rem2 >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else begin
				vld_s[i] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			op_s[i]  <= op_i;
			rem_s[i] <= ge ? rem2 - trial : rem2;
			res_s[i] <= {res_i[29:0], ge};
		end
	end

	assign out_vld = vld_s[N - 1];
	assign root    = res_s[N - 1];

endmodule

// ===== src/tagf_div.sv =====
// ----------------------------------------------------------------------------
// tagf_div
// three-lane pipelined rounded divide of the normal by its length
// ----------------------------------------------------------------------------
module tagf_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        vld,
	input  logic [29:0] mag [3],
	input  logic [30:0] root,
	output logic        out_vld,
	output logic [30:0] quo [3]
);

	localparam int N = tagf_pkg::DIV_STAGES;

	logic        vld_s [N];
	logic [30:0] r_s   [N];
	logic [59:0] num_s [N][3];
	logic [30:0] rem_s [N][3];
	logic [30:0] q_s   [N][3];

	for (genvar i = 0; i < N; i++) begin : g_st
		localparam int B = N - 1 - i;
		logic        vld_i;
		logic [30:0] r_i;

		if (i == 0) begin : g_first
			assign vld_i = vld;
			assign r_i   = root;
		end else begin : g_next
			assign vld_i = vld_s[i - 1];
			assign r_i   = r_s[i - 1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else begin
				vld_s[i] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			r_s[i] <= r_i;
		end

		for (genvar l = 0; l < 3; l++) begin : g_lane
			logic [59:0] num_i;
			logic [30:0] rem_i, q_i;
			logic [31:0] rem2;
			logic        ge;

			if (i == 0) begin : g_first
				assign num_i = {1'b0, mag[l], 29'd0} + 60'(root >> 1);
				assign rem_i = {2'b00, num_i[59:31]};
				assign q_i   = '0;
			end else begin : g_next
				assign num_i = num_s[i - 1][l];
				assign rem_i = rem_s[i - 1][l];
				assign q_i   = q_s[i - 1][l];
			end

			assign rem2 = {rem_i, num_i[B]};
			assign ge   = (rem2 >= {1'b0, r_i});

			always_ff @(posedge clk) begin
				num_s[i][l] <= num_i;
				rem_s[i][l] <= ge ? 31'(rem2 - {1'b0, r_i}) : 31'(rem2);
				q_s[i][l]   <= {q_i[29:0], ge};
			end
		end
	end

	assign out_vld = vld_s[N - 1];
	assign quo[0]  = q_s[N - 1][0];
	assign quo[1]  = q_s[N - 1][1];
	assign quo[2]  = q_s[N - 1][2];

endmodule

// ===== src/tagf_back.sv =====
// ----------------------------------------------------------------------------
// tagf_back
// edge cross unit normal, corner gradients, strength scaling, saturation and degenerate zeroing
// ----------------------------------------------------------------------------
module tagf_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 vld,
	input  tagf_pkg::nrm_t       nrm [3],
	input  tagf_pkg::edge_t      bc [3],
	input  tagf_pkg::edge_t      ca [3],
	input  logic                 degenerate,
	input  logic signed [31:0]   strength,
	output logic                 out_vld,
	output tagf_pkg::out_beat_t  result
);

	logic                vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic                dg_s1, dg_s2, dg_s3, dg_s4;
	logic signed [63:0]  pa_s1 [6], pb_s1 [6];
	logic signed [34:0]  ga_s2 [3], gb_s2 [3];
	logic signed [35:0]  g_s3 [9];
	logic signed [67:0]  f_s4 [9];
	tagf_pkg::out_beat_t res_s5;
	logic signed [31:0]  fo [9];

	function automatic logic signed [34:0] rnd30(input logic signed [64:0] x);
		logic [64:0] m, t;
		m = x[64] ? 65'(-x) : 65'(x);
		t = (m + (65'd1 << 29)) >> 30;
		return x[64] ? -$signed(t[34:0]) : $signed(t[34:0]);
	endfunction

	function automatic logic signed [31:0] rnd16sat(input logic signed [67:0] x);
		logic [67:0] m, t;
		m = x[67] ? 68'(-x) : 68'(x);
		t = (m + (68'd1 << 15)) >> 16;
		if (!x[67]) begin
			return (t > 68'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(t[31:0]);
		end
		return (t > 68'h8000_0000) ? 32'sh8000_0000 : -$signed(t[31:0]);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_comb begin
		for (int i = 0; i < 9; i++) begin
			fo[i] = rnd16sat(f_s4[i]);
		end
	end

	always_ff @(posedge clk) begin
		pa_s1[0] <= bc[1] * nrm[2];
		pa_s1[1] <= bc[2] * nrm[1];
		pa_s1[2] <= bc[2] * nrm[0];
		pa_s1[3] <= bc[0] * nrm[2];
		pa_s1[4] <= bc[0] * nrm[1];
		pa_s1[5] <= bc[1] * nrm[0];
		pb_s1[0] <= ca[1] * nrm[2];
		pb_s1[1] <= ca[2] * nrm[1];
		pb_s1[2] <= ca[2] * nrm[0];
		pb_s1[3] <= ca[0] * nrm[2];
		pb_s1[4] <= ca[0] * nrm[1];
		pb_s1[5] <= ca[1] * nrm[0];
		dg_s1    <= degenerate;
		for (int i = 0; i < 3; i++) begin
			ga_s2[i] <= rnd30(65'(pa_s1[2 * i]) - 65'(pa_s1[2 * i + 1]));
			gb_s2[i] <= rnd30(65'(pb_s1[2 * i]) - 65'(pb_s1[2 * i + 1]));
		end
		dg_s2 <= dg_s1;
		for (int i = 0; i < 3; i++) begin
			g_s3[i]     <= 36'(ga_s2[i]);
			g_s3[3 + i] <= 36'(gb_s2[i]);
			g_s3[6 + i] <= -(36'(ga_s2[i]) + 36'(gb_s2[i]));
		end
		dg_s3 <= dg_s2;
		for (int i = 0; i < 9; i++) begin
			f_s4[i] <= g_s3[i] * strength;
		end
		dg_s4 <= dg_s3;
		res_s5.fa_x       <= dg_s4 ? '0 : fo[0];
		res_s5.fa_y       <= dg_s4 ? '0 : fo[1];
		res_s5.fa_z       <= dg_s4 ? '0 : fo[2];
		res_s5.fb_x       <= dg_s4 ? '0 : fo[3];
		res_s5.fb_y       <= dg_s4 ? '0 : fo[4];
		res_s5.fb_z       <= dg_s4 ? '0 : fo[5];
		res_s5.fc_x       <= dg_s4 ? '0 : fo[6];
		res_s5.fc_y       <= dg_s4 ? '0 : fo[7];
		res_s5.fc_z       <= dg_s4 ? '0 : fo[8];
		res_s5.degenerate <= dg_s4;
	end

	assign out_vld = vld_s5;
	assign result  = res_s5;

endmodule

// ===== src/triangle_area_gradient_force_top.sv =====
// ----------------------------------------------------------------------------
// triangle_area_gradient_force_top
// area shrinking corner forces for one triangle per beat
// ----------------------------------------------------------------------------
// A triangle beat (three Q16.16 vertices) enters on start while busy is low.
// busy is high only during reset and until the first clock edge after it;
// afterwards one beat may enter every cycle, back to back, with up to 75
// triangles in flight. The result beat appears on result with done high for
// one cycle, after the front stages of edge, cross product, normalization
// and sum of squares, 31 square root stages (one root bit each), 31 divider
// stages (one quotient bit each), a normal clamp register and the back
// stages of gradient, scaling and saturation. Results leave in entry order.
// The receiver cannot stall; done is not held and a result is never repeated.
// cfg_wen with cfg_wdata writes force_strength (Q16.16); write it only while
// no triangle is in flight. Reset empties the pipeline and sets the
// strength to 1.0.
// ----------------------------------------------------------------------------
module triangle_area_gradient_force_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  tagf_pkg::in_beat_t   in_beat,
	output logic                 done,
	output tagf_pkg::out_beat_t  result,
	input  logic                 cfg_wen,
	input  logic [31:0]          cfg_wdata
);

	localparam int SIDE_DEPTH = tagf_pkg::SQRT_STAGES + tagf_pkg::DIV_STAGES;

	typedef struct packed {
		tagf_pkg::edge_t [2:0] bc;
		tagf_pkg::edge_t [2:0] ca;
		logic [2:0]            neg;
		logic                  degenerate;
	} side_t;

	logic               busy_q;
	logic signed [31:0] fs_q;

	logic               f_vld, f_dg, s_vld, d_vld, n_vld_s1;
	logic [29:0]        f_mag [3];
	logic [2:0]         f_neg;
	tagf_pkg::edge_t    f_bc [3], f_ca [3];
	logic [61:0]        f_sum;
	logic [30:0]        root;
	logic [30:0]        quo [3];
	side_t              side_in;
	side_t              side_s [SIDE_DEPTH];
	logic [29:0]        mag_s [tagf_pkg::SQRT_STAGES][3];
	tagf_pkg::nrm_t     nrm_s1 [3];
	side_t              side_s1;
	tagf_pkg::edge_t    b_bc [3], b_ca [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			fs_q   <= tagf_pkg::FS_RESET;
		end else begin
			busy_q <= 1'b0;
			if (cfg_wen) begin
				fs_q <= $signed(cfg_wdata);
			end
		end
	end

	assign busy = busy_q;

	tagf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.vld        (start && !busy_q),
		.beat       (in_beat),
		.out_vld    (f_vld),
		.v_mag      (f_mag),
		.v_neg      (f_neg),
		.degenerate (f_dg),
		.bc         (f_bc),
		.ca         (f_ca),
		.sum        (f_sum)
	);

	tagf_isqrt u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld     (f_vld),
		.op      (f_sum),
		.out_vld (s_vld),
		.root    (root)
	);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			side_in.bc[i] = f_bc[i];
			side_in.ca[i] = f_ca[i];
		end
		side_in.neg        = f_neg;
		side_in.degenerate = f_dg;
	end

	always_ff @(posedge clk) begin
		side_s[0] <= side_in;
		for (int i = 1; i < SIDE_DEPTH; i++) begin
			side_s[i] <= side_s[i - 1];
		end
		mag_s[0] <= f_mag;
		for (int i = 1; i < tagf_pkg::SQRT_STAGES; i++) begin
			mag_s[i] <= mag_s[i - 1];
		end
	end

	tagf_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld     (s_vld),
		.mag     (mag_s[tagf_pkg::SQRT_STAGES - 1]),
		.root    (root),
		.out_vld (d_vld),
		.quo     (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_vld_s1 <= 1'b0;
		end else begin
			n_vld_s1 <= d_vld;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			logic [29:0] q;
			q = (quo[i] > 31'(tagf_pkg::NRM_MAX)) ? tagf_pkg::NRM_MAX : quo[i][29:0];
			nrm_s1[i] <= side_s[SIDE_DEPTH - 1].neg[i] ? -$signed({1'b0, q})
			                                           : $signed({1'b0, q});
		end
		side_s1 <= side_s[SIDE_DEPTH - 1];
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			b_bc[i] = side_s1.bc[i];
			b_ca[i] = side_s1.ca[i];
		end
	end

	tagf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.vld        (n_vld_s1),
		.nrm        (nrm_s1),
		.bc         (b_bc),
		.ca         (b_ca),
		.degenerate (side_s1.degenerate),
		.strength   (fs_q),
		.out_vld    (done),
		.result     (result)
	);

endmodule

// ===== src/tagf_chk.sv =====
// ----------------------------------------------------------------------------
// tagf_chk
// port level checks on beat timing and degenerate results
// ----------------------------------------------------------------------------
module tagf_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input tagf_pkg::in_beat_t  in_beat,
	input logic                done,
	input tagf_pkg::out_beat_t result
);

	localparam int LAT = tagf_pkg::LATENCY;

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("result beat missing");

	a_done_caused: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result beat without a start beat");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.degenerate) |-> (result.fa_x == 0 && result.fa_y == 0 &&
		result.fa_z == 0 && result.fb_x == 0 && result.fb_y == 0 &&
		result.fb_z == 0 && result.fc_x == 0 && result.fc_y == 0 && result.fc_z == 0))
		else $error("degenerate beat with nonzero force");

	a_point_degen: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && in_beat.a_x == in_beat.b_x && in_beat.a_y == in_beat.b_y &&
		in_beat.a_z == in_beat.b_z) |-> ##LAT result.degenerate)
		else $error("coincident corners not flagged degenerate");

endmodule

bind triangle_area_gradient_force_top tagf_chk u_tagf_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.in_beat (in_beat),
	.done    (done),
	.result  (result)
);

// ===== sim/triangle_area_gradient_force_top_tb.sv =====
// ----------------------------------------------------------------------------
// triangle_area_gradient_force_top_tb
// checks the corner forces of the triangle area gradient unit beat by beat
// against a local fixed point predictor, over several force strengths, with
// random start gaps, a full drain mid run, degenerate and extreme triangles
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module triangle_area_gradient_force_top_tb;

	localparam int STALL_LIMIT = 4000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	tagf_pkg::in_beat_t   in_beat = '0;
	logic                 done;
	tagf_pkg::out_beat_t  result;
	logic                 cfg_wen = 1'b0;
	logic [31:0]          cfg_wdata = '0;

	tagf_pkg::in_beat_t  tri_pending[$];
	tagf_pkg::out_beat_t force_expect[$];
	logic signed [31:0]  strength = tagf_pkg::FS_RESET;
	int                  gap_left = 0;
	bit                  dense = 1'b0;
	int                  fails = 0;
	int                  quiet_cycles = 0;

	triangle_area_gradient_force_top DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .in_beat(in_beat),
		.done(done), .result(result), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic logic signed [127:0] round_shr(logic signed [127:0] x, int sh);
		logic signed [127:0] half;
		half = 128'sd1 <<< (sh - 1);
		if (x >= 0) return (x + half) >>> sh;
		return -((-x + half) >>> sh);
	endfunction

	function automatic logic signed [31:0] sat_q16(logic signed [127:0] x);
		if (x > 128'sd2147483647) return 32'sh7fff_ffff;
		if (x < -128'sd2147483648) return 32'sh8000_0000;
		return x[31:0];
	endfunction

	function automatic logic [63:0] floor_sqrt(logic [63:0] op);
		logic [63:0] res, one;
		res = 0;
		one = 64'h4000_0000_0000_0000;
		while (one > op) one = one >> 2;
		while (one != 0) begin
			if (op >= res + one) begin
				op = op - (res + one);
				res = (res >> 1) + one;
			end else begin
				res = res >> 1;
			end
			one = one >> 2;
		end
		return res;
	endfunction

	function automatic tagf_pkg::out_beat_t corner_forces(tagf_pkg::in_beat_t t,
		logic signed [31:0] s);
		logic signed [127:0] p[9];
		logic signed [127:0] ab[3], bc[3], ca[3], cr[3], nv[3], ga[3], gb[3], gc[3];
		logic [127:0]        mag[3];
		logic [63:0]         mv[3];
		logic [63:0]         sum, root, q;
		logic signed [31:0]  fo[9];
		int                  len;
		tagf_pkg::out_beat_t o;
		p[0] = t.a_x; p[1] = t.a_y; p[2] = t.a_z;
		p[3] = t.b_x; p[4] = t.b_y; p[5] = t.b_z;
		p[6] = t.c_x; p[7] = t.c_y; p[8] = t.c_z;
		for (int i = 0; i < 3; i++) begin
			ab[i] = p[3 + i] - p[i];
			bc[i] = p[6 + i] - p[3 + i];
			ca[i] = p[i] - p[6 + i];
		end
		cr[0] = ab[1] * bc[2] - ab[2] * bc[1];
		cr[1] = ab[2] * bc[0] - ab[0] * bc[2];
		cr[2] = ab[0] * bc[1] - ab[1] * bc[0];
		len = 0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = (cr[i] < 0) ? -cr[i] : cr[i];
			for (int j = 0; j < 128; j++)
				if (mag[i][j] && j + 1 > len) len = j + 1;
		end
		o = '0;
		if (len == 0) begin
			o.degenerate = 1'b1;
			return o;
		end
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			if (len > 30) mv[i] = 64'(mag[i] >> (len - 30));
			else mv[i] = 64'(mag[i] << (30 - len));
			mv[i] = mv[i] & 64'h3fff_ffff;
			sum = sum + mv[i] * mv[i];
		end
		root = floor_sqrt(sum);
		for (int i = 0; i < 3; i++) begin
			q = ((mv[i] << 29) + (root >> 1)) / root;
			if (q > 64'(tagf_pkg::NRM_MAX)) q = 64'(tagf_pkg::NRM_MAX);
			nv[i] = (cr[i] < 0) ? -$signed({64'd0, q}) : $signed({64'd0, q});
		end
		ga[0] = round_shr(bc[1] * nv[2] - bc[2] * nv[1], 30);
		ga[1] = round_shr(bc[2] * nv[0] - bc[0] * nv[2], 30);
		ga[2] = round_shr(bc[0] * nv[1] - bc[1] * nv[0], 30);
		gb[0] = round_shr(ca[1] * nv[2] - ca[2] * nv[1], 30);
		gb[1] = round_shr(ca[2] * nv[0] - ca[0] * nv[2], 30);
		gb[2] = round_shr(ca[0] * nv[1] - ca[1] * nv[0], 30);
		for (int i = 0; i < 3; i++) begin
			gc[i] = -(ga[i] + gb[i]);
			fo[i]     = sat_q16(round_shr(ga[i] * s, 16));
			fo[3 + i] = sat_q16(round_shr(gb[i] * s, 16));
			fo[6 + i] = sat_q16(round_shr(gc[i] * s, 16));
		end
		o = {fo[0], fo[1], fo[2], fo[3], fo[4], fo[5], fo[6], fo[7], fo[8], 1'b0};
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		fails++;
		if (fails <= 40)
			$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
	endtask

	function automatic int next_gap();
		int r;
		if (dense) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(20, 60);
	endfunction

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			in_beat <= '0;
			gap_left <= 0;
		end else begin
			if (start && !busy) force_expect.push_back(corner_forces(in_beat, strength));
			if (!start || !busy) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					start <= 1'b0;
				end else if (tri_pending.size() > 0) begin
					in_beat <= tri_pending.pop_front();
					start <= 1'b1;
					gap_left <= next_gap();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		tagf_pkg::out_beat_t want;
		string               names[9];
		names = '{"fa_x", "fa_y", "fa_z", "fb_x", "fb_y", "fb_z", "fc_x", "fc_y", "fc_z"};
		if (arst_n && done) begin
			if (force_expect.size() == 0) begin
				report_mismatch("unexpected beat", result[288 -: 32], '0);
			end else begin
				want = force_expect.pop_front();
				for (int i = 0; i < 9; i++)
					if (result[288 - 32 * i -: 32] !== want[288 - 32 * i -: 32])
						report_mismatch(names[i], result[288 - 32 * i -: 32],
							want[288 - 32 * i -: 32]);
				if (result.degenerate !== want.degenerate)
					report_mismatch("degenerate", 32'(result.degenerate),
						32'(want.degenerate));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic add_tri(logic [31:0] ax, ay, az, bx, by, bz, cx, cy, cz);
		tri_pending.push_back({ax, ay, az, bx, by, bz, cx, cy, cz});
	endtask

	task automatic add_random_tri();
		int          mode;
		logic [31:0] v[9];
		logic [31:0] base, d[3];
		mode = $urandom_range(0, 99);
		for (int i = 0; i < 9; i++) v[i] = $urandom();
		if (mode < 35) begin
			// arbitrary coordinates
		end else if (mode < 70) begin
			// compact triangle near a random point
			for (int k = 0; k < 3; k++) begin
				base = $urandom_range(0, 1) ? $urandom()
					: 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
				for (int j = 0; j < 3; j++)
					v[3 * j + k] = base
						+ 32'($signed($urandom_range(0, 1 << (6 + $urandom_range(0, 16))))
						- $signed(32'(1 << 12)));
			end
		end else if (mode < 85) begin
			// collinear or coincident corners
			for (int k = 0; k < 3; k++) begin
				d[k] = $urandom_range(0, 3) == 0 ? 32'd0
					: 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
				v[3 + k] = v[k] + d[k];
				v[6 + k] = v[k] + (d[k] << 1);
			end
		end else begin
			// some fields pinned to the extremes
			for (int i = 0; i < 9; i++)
				case ($urandom_range(0, 3))
					0: v[i] = 32'h7fff_ffff;
					1: v[i] = 32'h8000_0000;
					default: ;
				endcase
		end
		add_tri(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]);
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (tri_pending.size() != 0 || start || force_expect.size() != 0);
		repeat (tagf_pkg::LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_strength(logic [31:0] val);
		cfg_wen <= 1'b1;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wen <= 1'b0;
		strength = val;
		@(posedge clk);
	endtask

	initial begin
		logic [31:0] strengths[7];
		strengths = '{32'h0001_0000, 32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000,
			32'hffff_0000, 32'h0000_0001, 32'h0000_0000};
		strengths[6] = $urandom();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed shapes at the reset strength
		add_tri(0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_tri(0, 0, 0, 32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0);
		add_tri(0, 0, 0, 0, 32'h0001_0000, 0, 0, 0, 32'h0001_0000);
		add_tri(0, 0, 0, 0, 0, 32'h0001_0000, 32'h0001_0000, 0, 0);
		add_tri(0, 0, 0, 1, 0, 0, 0, 1, 0);
		add_tri(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
		add_tri(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
			32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
		add_tri(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		add_tri(0, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0002_0000,
			32'h0002_0000, 32'h0002_0000);
		add_tri(32'h8000_0000, 0, 0, 32'h7fff_ffff, 0, 0, 0, 32'h7fff_ffff, 32'h8000_0000);
		add_tri(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0, 0, 0, 1, 1, 0);
		add_tri(32'h0000_1000, 32'h0003_0000, 32'hfff0_0000, 32'h0000_1000, 32'h0003_0000,
			32'hfff0_0000, 32'h0123_4567, 32'h89ab_cdef, 32'h5555_aaaa);
		add_tri(32'h0010_0000, 0, 0, 0, 32'h0010_0000, 0, 0, 0, 32'h0010_0000);
		add_tri(32'haaaa_5555, 32'h5555_aaaa, 32'h0f0f_f0f0, 32'hf0f0_0f0f, 32'h3333_cccc,
			32'hcccc_3333, 32'h6969_9696, 32'h9696_6969, 32'h0000_0000);
		wait_drained();

		for (int ph = 0; ph < 7; ph++) begin
			write_strength(strengths[ph]);
			dense = (ph == 3);
			for (int n = 0; n < 125; n++) begin
				add_random_tri();
				if (ph == 2 && n == 60) wait_drained();
			end
			wait_drained();
		end

		if (fails == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end

endmodule

// ===== files.f =====
src/tagf_pkg.sv
src/tagf_front.sv
src/tagf_isqrt.sv
src/tagf_div.sv
src/tagf_back.sv
src/triangle_area_gradient_force_top.sv
src/tagf_chk.sv
sim/triangle_area_gradient_force_top_tb.sv
